### rtl/core/keyed_block_range_overlap_table_defines.svh
// Assertion macros shared by the RTL of the overlap table.
`ifndef KEYED_BLOCK_RANGE_OVERLAP_TABLE_DEFINES_SVH
`define KEYED_BLOCK_RANGE_OVERLAP_TABLE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define KBROT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Antecedent implies consequent on the next clock edge.
`define KBROT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/kbrot_pkg.sv
`timescale 1ns / 1ps

package kbrot_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned ResultCap     = 16;
  localparam int unsigned KeyW          = 64;
  localparam int unsigned BlkW          = 64;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned CountOutW     = 5;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIRST  = 2'd2;
  localparam logic [1:0] OP_ALL    = 2'd3;

  localparam logic [StatusW-1:0] ST_OK          = 3'd0;
  localparam logic [StatusW-1:0] ST_KEY_EXISTS  = 3'd1;
  localparam logic [StatusW-1:0] ST_KEY_MISSING = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL        = 3'd3;
  localparam logic [StatusW-1:0] ST_NO_OVERLAP  = 3'd4;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [BlkW-1:0] rstart;
    logic [BlkW-1:0] rend;
  } kbrot_entry_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic eval;    // latch key match and insert position flags
    logic insert;  // open a gap at the insert position and fill it
    logic remove;  // close the gap left by the matching entry
    logic rotate;  // shift the whole chain one cell toward the head
  } kbrot_ctl_t;

endpackage

### rtl/core/keyed_block_range_overlap_table.sv
`timescale 1ns / 1ps
`include "keyed_block_range_overlap_table_defines.svh"

// Keyed overlap table for in-flight block range conflict checks. Entries
// live in a chain of TABLE_DEPTH cells kept sorted by rank (end, then
// start, then key, all ascending) with the valid entries packed at the
// head. Add and remove run through these steps from acceptance to result:
// the request is accepted, every cell compares the key and its rank
// against the request, and the chain opens or closes a gap once the
// output register can take the result. Both queries walk the whole
// chain: it rotates one cell per cycle while the output register can
// take a transaction, the head cell is tested against the query range,
// and after TABLE_DEPTH steps the table is back in place.
// All-overlap runs are cut after 16 results; the last transaction of every
// item carries last_o. entry_count_o is the count after the operation, kept
// to its low five bits. A new item is taken only once the previous one has
// produced all its results; a finished result may still sit in the output
// register waiting while the next item is accepted.
module keyed_block_range_overlap_table #(
  parameter int unsigned TABLE_DEPTH = kbrot_pkg::TableDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic [kbrot_pkg::KeyW-1:0]       key_i,
  input  logic [kbrot_pkg::BlkW-1:0]       range_start_i,
  input  logic [kbrot_pkg::BlkW-1:0]       range_end_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kbrot_pkg::StatusW-1:0]    status_o,
  output logic [kbrot_pkg::KeyW-1:0]       hit_key_o,
  output logic [kbrot_pkg::BlkW-1:0]       hit_start_o,
  output logic [kbrot_pkg::BlkW-1:0]       hit_end_o,
  output logic [kbrot_pkg::CountOutW-1:0]  entry_count_o,
  output logic                             last_o
);

  localparam int unsigned CntW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned StepW  = $clog2(TABLE_DEPTH);
  localparam int unsigned FoundW = $clog2(kbrot_pkg::ResultCap + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [1:0]                 op_q;
  logic [kbrot_pkg::KeyW-1:0] qkey_q;
  logic [kbrot_pkg::BlkW-1:0] qs_q;
  logic [kbrot_pkg::BlkW-1:0] qe_q;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [StepW-1:0]           step_q, step_d;
  logic [FoundW-1:0]          found_q, found_d;
  logic [FoundW-1:0]          limit;

  logic                       pend_vld_q, pend_vld_d;
  kbrot_pkg::kbrot_entry_t    pend_q, pend_d;

  logic                            out_vld_q, out_vld_d;
  logic [kbrot_pkg::StatusW-1:0]   out_st_q, out_st_d;
  logic [kbrot_pkg::KeyW-1:0]      out_key_q, out_key_d;
  logic [kbrot_pkg::BlkW-1:0]      out_s_q, out_s_d;
  logic [kbrot_pkg::BlkW-1:0]      out_e_q, out_e_d;
  logic [kbrot_pkg::CountOutW-1:0] out_cnt_q, out_cnt_d;
  logic                            out_last_q, out_last_d;

  logic                    out_free;
  logic                    in_acc;
  kbrot_pkg::kbrot_ctl_t   ctl;
  kbrot_pkg::kbrot_entry_t ent      [TABLE_DEPTH];
  kbrot_pkg::kbrot_entry_t left_ent [TABLE_DEPTH];
  kbrot_pkg::kbrot_entry_t right_ent[TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  ins_vec;
  logic [TABLE_DEPTH-1:0]  ins_left;
  logic [TABLE_DEPTH-1:0]  match_vec;
  logic [TABLE_DEPTH-1:0]  pfx_in;
  logic [TABLE_DEPTH-1:0]  pfx_out;
  logic [TABLE_DEPTH-1:0]  vld_vec;
  logic                    any_match;
  logic                    head_ov;
  kbrot_pkg::kbrot_entry_t head;

  // ---------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_link
    if (i == 0) begin : g_head
      assign left_ent[i] = '0;
      assign ins_left[i] = 1'b0;
      assign pfx_in[i]   = 1'b0;
    end else begin : g_body
      assign left_ent[i] = ent[i-1];
      assign ins_left[i] = ins_vec[i-1];
      assign pfx_in[i]   = pfx_out[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      // rotation wraps the head around; removal pulls in an empty entry
      assign right_ent[i] = ctl.rotate ? ent[0] : '0;
    end else begin : g_inner
      assign right_ent[i] = ent[i+1];
    end
    assign vld_vec[i] = ent[i].valid;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kbrot_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .q_key_i    (qkey_q),
      .q_start_i  (qs_q),
      .q_end_i    (qe_q),
      .left_i     (left_ent[i]),
      .right_i    (right_ent[i]),
      .ins_left_i (ins_left[i]),
      .pfx_i      (pfx_in[i]),
      .ent_o      (ent[i]),
      .ins_o      (ins_vec[i]),
      .match_o    (match_vec[i]),
      .pfx_o      (pfx_out[i])
    );
  end

  assign any_match = |match_vec;
  assign head      = ent[0];
  assign head_ov   = head.valid && (head.rstart <= qe_q) && (qs_q <= head.rend);
  assign limit     = (op_q == kbrot_pkg::OP_FIRST) ? FoundW'(1)
                                                    : FoundW'(kbrot_pkg::ResultCap);

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    found_d    = found_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    ctl        = '0;

    out_vld_d  = out_vld_q && !out_ready_i;
    out_st_d   = out_st_q;
    out_key_d  = out_key_q;
    out_s_d    = out_s_q;
    out_e_d    = out_e_q;
    out_cnt_d  = out_cnt_q;
    out_last_d = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          step_d     = '0;
          found_d    = '0;
          pend_vld_d = 1'b0;
          if ((op_i == kbrot_pkg::OP_ADD) || (op_i == kbrot_pkg::OP_REMOVE)) begin
            state_d = S_EVAL;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_EVAL: begin
        ctl.eval = 1'b1;
        state_d  = S_ACT;
      end
      S_ACT: begin
        if (out_free) begin
          out_key_d  = '0;
          out_s_d    = '0;
          out_e_d    = '0;
          out_last_d = 1'b1;
          out_vld_d  = 1'b1;
          if (op_q == kbrot_pkg::OP_ADD) begin
            if (any_match) begin
              out_st_d = kbrot_pkg::ST_KEY_EXISTS;
            end else if (cnt_q == CntW'(TABLE_DEPTH)) begin
              out_st_d = kbrot_pkg::ST_FULL;
            end else begin
              out_st_d   = kbrot_pkg::ST_OK;
              ctl.insert = 1'b1;
              cnt_d      = cnt_q + CntW'(1);
            end
          end else begin
            if (any_match) begin
              out_st_d   = kbrot_pkg::ST_OK;
              ctl.remove = 1'b1;
              cnt_d      = cnt_q - CntW'(1);
            end else begin
              out_st_d = kbrot_pkg::ST_KEY_MISSING;
            end
          end
          out_cnt_d = kbrot_pkg::CountOutW'(cnt_d);
          state_d   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          ctl.rotate = 1'b1;
          if (head_ov && (found_q != limit)) begin
            // hold one hit back so the final one can carry last
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_st_d   = kbrot_pkg::ST_OK;
              out_key_d  = pend_q.key;
              out_s_d    = pend_q.rstart;
              out_e_d    = pend_q.rend;
              out_cnt_d  = kbrot_pkg::CountOutW'(cnt_q);
              out_last_d = 1'b0;
            end
            pend_d     = head;
            pend_vld_d = 1'b1;
            found_d    = found_q + FoundW'(1);
          end
          step_d = step_q + StepW'(1);
          if (step_q == StepW'(TABLE_DEPTH - 1)) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_cnt_d  = kbrot_pkg::CountOutW'(cnt_q);
          out_last_d = 1'b1;
          if (pend_vld_q) begin
            out_st_d  = kbrot_pkg::ST_OK;
            out_key_d = pend_q.key;
            out_s_d   = pend_q.rstart;
            out_e_d   = pend_q.rend;
          end else begin
            out_st_d  = kbrot_pkg::ST_NO_OVERLAP;
            out_key_d = '0;
            out_s_d   = '0;
            out_e_d   = '0;
          end
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      step_q     <= '0;
      found_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      step_q     <= step_d;
      found_q    <= found_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_i;
      qkey_q <= key_i;
      qs_q   <= range_start_i;
      qe_q   <= range_end_i;
    end
    pend_q     <= pend_d;
    out_st_q   <= out_st_d;
    out_key_q  <= out_key_d;
    out_s_q    <= out_s_d;
    out_e_q    <= out_e_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_st_q;
  assign hit_key_o     = out_key_q;
  assign hit_start_o   = out_s_q;
  assign hit_end_o     = out_e_q;
  assign entry_count_o = out_cnt_q;
  assign last_o        = out_last_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `KBROT_ASSERT(a_count_tracks_cells, $countones(vld_vec) == cnt_q, "entry count mismatch")
  `KBROT_ASSERT_NEXT(a_packed_at_rest, state_q == S_IDLE, ((vld_vec & (vld_vec + TABLE_DEPTH'(1))) == '0) || (state_q != S_IDLE), "valid entries not packed at head")
  `KBROT_ASSERT(a_found_capped, found_q <= FoundW'(kbrot_pkg::ResultCap), "run exceeds cap")
  `KBROT_ASSERT_NEXT(a_scan_restores, (state_q == S_SCAN) && out_free && (step_q == StepW'(TABLE_DEPTH - 1)), (state_q == S_FIN) && ((vld_vec & (vld_vec + TABLE_DEPTH'(1))) == '0), "rotation did not restore chain")

endmodule

### rtl/core/kbrot_cell.sv
`timescale 1ns / 1ps

module kbrot_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kbrot_pkg::kbrot_ctl_t         ctl_i,
  input  logic [kbrot_pkg::KeyW-1:0]    q_key_i,
  input  logic [kbrot_pkg::BlkW-1:0]    q_start_i,
  input  logic [kbrot_pkg::BlkW-1:0]    q_end_i,
  input  kbrot_pkg::kbrot_entry_t       left_i,
  input  kbrot_pkg::kbrot_entry_t       right_i,
  input  logic                          ins_left_i,
  input  logic                          pfx_i,
  output kbrot_pkg::kbrot_entry_t       ent_o,
  output logic                          ins_o,
  output logic                          match_o,
  output logic                          pfx_o
);

  logic                       valid_q;
  logic [kbrot_pkg::KeyW-1:0] key_q;
  logic [kbrot_pkg::BlkW-1:0] start_q;
  logic [kbrot_pkg::BlkW-1:0] end_q;
  logic                       ins_q;
  logic                       match_q;
  logic                       new_before;
  kbrot_pkg::kbrot_entry_t    new_ent;
  kbrot_pkg::kbrot_entry_t    ent_d;

  assign ent_o   = {valid_q, key_q, start_q, end_q};
  assign new_ent = {1'b1, q_key_i, q_start_i, q_end_i};

  // rank: end ascending, then start ascending, then key ascending
  assign new_before = (q_end_i < end_q) ||
                      ((q_end_i == end_q) && ((q_start_i < start_q) ||
                       ((q_start_i == start_q) && (q_key_i < key_q))));

  assign ins_o   = ins_q;
  assign match_o = match_q;
  assign pfx_o   = pfx_i | match_q;

  always_comb begin
    ent_d = ent_o;
    if (ctl_i.insert && ins_q) begin
      ent_d = ins_left_i ? left_i : new_ent;
    end else if (ctl_i.remove && pfx_o) begin
      ent_d = right_i;
    end else if (ctl_i.rotate) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ins_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= ent_d.valid;
      if (ctl_i.eval) begin
        ins_q   <= !valid_q || new_before;
        match_q <= valid_q && (key_q == q_key_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= ent_d.key;
    start_q <= ent_d.rstart;
    end_q   <= ent_d.rend;
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the keyed overlap table. A short table of
// hand-written transactions walks the corner cases first: empty table,
// duplicate keys, full table, reversed ranges, equal-end ties and a
// 16-entry all-overlap run. After that, a random mix of adds, removes and
// queries runs. Every accepted input is fed to an in-bench table model,
// and every output transaction is checked against the oldest awaited
// result, given by the directed row where it has one, else by the model.
module tb_top;
  import kbrot_pkg::*;

  localparam int unsigned Depth       = TableDepthDef;
  localparam int unsigned RandItems   = 85;
  localparam int unsigned KeyPoolSize = 24;
  localparam int unsigned CycleLimit  = 400000;
  localparam logic [63:0] AllOnes     = '1;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [KeyW-1:0]      hit_key;
    logic [BlkW-1:0]      hit_start;
    logic [BlkW-1:0]      hit_end;
    logic [CountOutW-1:0] count;
    logic                 last;
  } table_rsp_t;

  // One directed stimulus row. When typed is set, the expected single
  // result (status and count, hit fields zero, last high) is given here.
  typedef struct packed {
    logic [1:0]           op;
    logic [KeyW-1:0]      key;
    logic [BlkW-1:0]      rs;
    logic [BlkW-1:0]      re;
    bit                   typed;
    logic [StatusW-1:0]   status;
    logic [CountOutW-1:0] count;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           op_i;
  logic [KeyW-1:0]      key_i;
  logic [BlkW-1:0]      range_start_i;
  logic [BlkW-1:0]      range_end_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [StatusW-1:0]   status_o;
  logic [KeyW-1:0]      hit_key_o;
  logic [BlkW-1:0]      hit_start_o;
  logic [BlkW-1:0]      hit_end_o;
  logic [CountOutW-1:0] entry_count_o;
  logic                 last_o;

  // Shadow copy of the table.
  bit          tbl_valid [Depth];
  logic [63:0] tbl_key   [Depth];
  logic [63:0] tbl_start [Depth];
  logic [63:0] tbl_end   [Depth];

  table_rsp_t  fresh_rsp[$];    // results of the item just applied
  table_rsp_t  awaited_rsp[$];  // results still owed by the block
  stim_row_t   directed_rows[$];

  logic [63:0] key_pool [KeyPoolSize];
  logic [63:0] region_base [4];

  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          longest_run = 0;
  int          op_seen [4] = '{0, 0, 0, 0};
  int          burst_left = 0;
  int unsigned cyc = 0;
  bit [5:0]    rdy_phase = '0;
  int          rdy_mode = 0;

  keyed_block_range_overlap_table #(
    .TABLE_DEPTH(Depth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .key_i         (key_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .hit_key_o     (hit_key_o),
    .hit_start_o   (hit_start_o),
    .hit_end_o     (hit_end_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("Timed out after %0d cycles, %0d results still awaited", cyc,
               awaited_rsp.size());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: each time rdy_phase wraps, pick a new pattern
  // (always ready, coin flip, one in four, alternating on and off runs).
  always @(posedge clk_i) begin
    rdy_phase <= rdy_phase + 1'b1;
    if (rdy_phase == '0) rdy_mode <= $urandom_range(0, 3);
    case (rdy_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= (rdy_phase[1:0] == 2'd3);
      default: out_ready_i <= ~rdy_phase[2];
    endcase
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("%0t: result %0d: %s got %h want %h", $realtime, results_seen,
             what, got, want);
  endtask

  function automatic int live_entries();
    int n;
    n = 0;
    for (int i = 0; i < Depth; i++) if (tbl_valid[i]) n++;
    return n;
  endfunction

  function automatic void push_rsp(logic [StatusW-1:0] st, logic [63:0] hk,
                                   logic [63:0] hs, logic [63:0] he, logic lst);
    table_rsp_t r;
    r.status    = st;
    r.hit_key   = hk;
    r.hit_start = hs;
    r.hit_end   = he;
    r.count     = CountOutW'(live_entries());
    r.last      = lst;
    fresh_rsp.push_back(r);
  endfunction

  // Rank: end ascending, then start ascending, then key ascending.
  function automatic bit outranks(int a, int b);
    if (tbl_end[a] != tbl_end[b]) return tbl_end[a] < tbl_end[b];
    if (tbl_start[a] != tbl_start[b]) return tbl_start[a] < tbl_start[b];
    return tbl_key[a] < tbl_key[b];
  endfunction

  // Apply one item to the shadow table and leave its results in fresh_rsp.
  function automatic void apply_table_op(logic [1:0] op, logic [63:0] k,
                                         logic [63:0] qs, logic [63:0] qe);
    int hit_slot;
    int free_slot;
    int order [Depth];
    int n;
    int j;
    fresh_rsp.delete();
    hit_slot  = -1;
    free_slot = -1;
    n         = 0;
    for (int i = 0; i < Depth; i++) begin
      if (tbl_valid[i] && tbl_key[i] == k && hit_slot < 0) hit_slot = i;
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
    end
    case (op)
      OP_ADD: begin
        // duplicate key is reported ahead of a full table
        if (hit_slot >= 0) push_rsp(ST_KEY_EXISTS, '0, '0, '0, 1'b1);
        else if (free_slot < 0) push_rsp(ST_FULL, '0, '0, '0, 1'b1);
        else begin
          tbl_valid[free_slot] = 1'b1;
          tbl_key[free_slot]   = k;
          tbl_start[free_slot] = qs;
          tbl_end[free_slot]   = qe;
          push_rsp(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (hit_slot < 0) push_rsp(ST_KEY_MISSING, '0, '0, '0, 1'b1);
        else begin
          tbl_valid[hit_slot] = 1'b0;
          push_rsp(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      default: begin
        // plain unsigned compares; reversed ranges are taken as they are
        for (int i = 0; i < Depth; i++) begin
          if (tbl_valid[i] && tbl_start[i] <= qe && qs <= tbl_end[i]) begin
            j = n;
            while (j > 0 && outranks(i, order[j-1])) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = i;
            n++;
          end
        end
        if (n == 0) push_rsp(ST_NO_OVERLAP, '0, '0, '0, 1'b1);
        else begin
          if (op == OP_FIRST) n = 1;
          if (n > ResultCap) n = ResultCap;
          for (int m = 0; m < n; m++)
            push_rsp(ST_OK, tbl_key[order[m]], tbl_start[order[m]],
                     tbl_end[order[m]], m == n - 1);
        end
      end
    endcase
  endfunction

  function automatic void push_row(logic [1:0] op, logic [63:0] k, logic [63:0] s,
                                   logic [63:0] e, bit typed,
                                   logic [StatusW-1:0] st, logic [CountOutW-1:0] cnt);
    stim_row_t row;
    row.op     = op;
    row.key    = k;
    row.rs     = s;
    row.re     = e;
    row.typed  = typed;
    row.status = st;
    row.count  = cnt;
    directed_rows.push_back(row);
  endfunction

  // Ranges mostly fall in small windows of one of four regions, so that
  // entries overlap often; now and then reversed or a single block.
  function automatic void pick_range(output logic [63:0] s, output logic [63:0] e);
    s = region_base[$urandom_range(0, 3)] + 64'($urandom_range(0, 255));
    case ($urandom_range(0, 15))
      0: e = s - 64'($urandom_range(1, 20));
      1: e = s;
      default: e = s + 64'($urandom_range(0, 40));
    endcase
  endfunction

  // Present one item and hold it until the block takes it. Called at a
  // clock edge; returns at the edge of acceptance.
  task automatic send_item(input stim_row_t row);
    table_rsp_t r;
    in_valid_i    <= 1'b1;
    op_i          <= row.op;
    key_i         <= row.key;
    range_start_i <= row.rs;
    range_end_i   <= row.re;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    apply_table_op(row.op, row.key, row.rs, row.re);
    if (row.typed) begin
      r = '{row.status, '0, '0, '0, row.count, 1'b1};
      awaited_rsp.push_back(r);
    end else begin
      foreach (fresh_rsp[m]) awaited_rsp.push_back(fresh_rsp[m]);
    end
    op_seen[row.op]++;
    items_sent++;
  endtask

  // Sender bursts: keep valid up within a burst, else drop it for a gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = ($urandom_range(0, 7) == 0) ? 25 : $urandom_range(0, 9);
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_rsp.size() != 0);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    table_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_rsp.size() == 0) begin
        flag_mismatch("transaction with nothing awaited, status", 64'(status_o), '0);
      end else begin
        want = awaited_rsp.pop_front();
        if (status_o !== want.status)
          flag_mismatch("status", 64'(status_o), 64'(want.status));
        if (hit_key_o !== want.hit_key) flag_mismatch("hit_key", hit_key_o, want.hit_key);
        if (hit_start_o !== want.hit_start)
          flag_mismatch("hit_start", hit_start_o, want.hit_start);
        if (hit_end_o !== want.hit_end) flag_mismatch("hit_end", hit_end_o, want.hit_end);
        if (entry_count_o !== want.count)
          flag_mismatch("entry_count", 64'(entry_count_o), 64'(want.count));
        if (last_o !== want.last) flag_mismatch("last", 64'(last_o), 64'(want.last));
      end
      results_seen++;
    end
  end

  // Longest run of query hits seen on the output.
  int run_len = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (last_o) begin
        if (run_len + 1 > longest_run) longest_run = run_len + 1;
        run_len = 0;
      end else begin
        run_len = run_len + 1;
      end
    end
  end

  initial begin
    stim_row_t   row;
    logic [63:0] s;
    logic [63:0] e;
    int          r;
    int          add_pct;
    int          pick;
    in_valid_i    = 1'b0;
    op_i          = OP_ADD;
    key_i         = '0;
    range_start_i = '0;
    range_end_i   = '0;

    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = AllOnes;
    region_base[0] = '0;
    region_base[1] = {$urandom, $urandom} & ~64'hFFF;
    region_base[2] = 64'hFFFF_FFFF_FFFF_F000;
    region_base[3] = {$urandom, 32'h0};

    // Directed table.
    push_row(OP_FIRST,  64'h0,    64'h0,   AllOnes, 1'b1, ST_NO_OVERLAP,  5'd0); // empty
    push_row(OP_REMOVE, 64'h5,    64'h0,   64'h0,   1'b1, ST_KEY_MISSING, 5'd0);
    push_row(OP_ADD,    64'h0,    64'h0,   64'h0,   1'b1, ST_OK,          5'd1);
    push_row(OP_ADD,    AllOnes,  AllOnes, AllOnes, 1'b1, ST_OK,          5'd2);
    push_row(OP_ADD,    64'h0,    64'h7,   64'h9,   1'b1, ST_KEY_EXISTS,  5'd2);
    push_row(OP_ADD,    64'h1234, 64'd100, 64'd200, 1'b1, ST_OK,          5'd3);
    push_row(OP_ADD,    64'h1235, 64'd100, 64'd200, 1'b1, ST_OK,          5'd4); // tie, key
    push_row(OP_ADD,    64'h7,    64'd50,  64'd200, 1'b1, ST_OK,          5'd5); // longer
    push_row(OP_ADD,    64'h9,    64'd300, 64'd250, 1'b1, ST_OK,          5'd6); // reversed
    for (int i = 0; i < 10; i++)
      push_row(OP_ADD, {32'hC3C3_0000 + i, 32'h0F0F_A5A5 ^ i}, 64'(120 + 5 * i),
               64'(260 - 4 * i), 1'b1, ST_OK, CountOutW'(7 + i));
    push_row(OP_ADD,    64'h4242, 64'd0,   64'd10,  1'b1, ST_FULL,        5'd16);
    push_row(OP_ADD,    64'h7,    64'd0,   64'd10,  1'b1, ST_KEY_EXISTS,  5'd16); // not full
    push_row(OP_ALL,    64'h0,    64'h0,   AllOnes, 1'b0, ST_OK,          5'd0); // 16 hits
    push_row(OP_FIRST,  AllOnes,  64'd150, 64'd150, 1'b0, ST_OK,          5'd0);
    push_row(OP_ALL,    64'h0,    AllOnes, 64'h0,   1'b0, ST_OK,          5'd0); // reversed
    push_row(OP_REMOVE, 64'h1234, 64'h0,   64'h0,   1'b1, ST_OK,          5'd15);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
      pace_sender();
    end
    wait_drained();

    // Random mix; adds lean ahead of removes so the table fills and empties.
    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems / 2) wait_drained();
      row = '0;
      pick_range(s, e);
      row.rs  = s;
      row.re  = e;
      r       = $urandom_range(0, 99);
      add_pct = (live_entries() >= Depth - 1) ? 30 : 45;
      if (r < add_pct) begin
        row.op  = OP_ADD;
        row.key = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom}
                                               : key_pool[$urandom_range(0, KeyPoolSize-1)];
      end else if (r < add_pct + 25) begin
        row.op  = OP_REMOVE;
        row.key = key_pool[$urandom_range(0, KeyPoolSize-1)];
        if ($urandom_range(0, 3) != 0) begin
          // usually a key that is present
          pick = $urandom_range(0, Depth-1);
          for (int i = 0; i < Depth; i++)
            if (tbl_valid[(pick + i) % Depth]) begin
              row.key = tbl_key[(pick + i) % Depth];
              break;
            end
        end
      end else begin
        row.op  = (r < add_pct + 40) ? OP_FIRST : OP_ALL;
        row.key = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          0: begin row.rs = '0; row.re = AllOnes; end
          1: begin row.rs = {$urandom, $urandom}; row.re = {$urandom, $urandom}; end
          default: ;
        endcase
      end
      send_item(row);
      pace_sender();
    end

    wait_drained();
    repeat (2 * Depth + 8) @(posedge clk_i);

    $display("Covered %0d items: %0d add, %0d remove, %0d first-hit, %0d all-hit",
             items_sent, op_seen[OP_ADD], op_seen[OP_REMOVE], op_seen[OP_FIRST],
             op_seen[OP_ALL]);
    $display("Checked %0d result transactions, longest run %0d, %0d mismatches",
             results_seen, longest_run, mismatches);
    if (mismatches == 0 && awaited_rsp.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/kbrot_pkg.sv
rtl/core/kbrot_cell.sv
rtl/core/keyed_block_range_overlap_table.sv
sim/tb_top.sv
